// ===== src/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope gain pipeline.
// No dependencies; imported by every module of the block.
package adsr_pkg;

	localparam int unsigned FULL_SCALE = 65536;
	localparam int unsigned LEN_W      = 24;
	localparam int unsigned GAIN_W     = 17;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned NUM_W      = 41;
	localparam int unsigned DIV_STAGES = 17;

	typedef enum logic [1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] attack_length;
		logic [LEN_W-1:0] decay_length;
		logic [GAIN_W-1:0] sustain_gain;
		logic [LEN_W-1:0] release_length;
	} cfg_t;

	// Sideband that rides along with a division
	typedef struct packed {
		logic              bypass;
		logic [GAIN_W-1:0] bypass_val;
		logic              rel;
		logic              rel_zero;
		logic [LEN_W-1:0]  rem_time;
	} side_t;

endpackage

// ===== src/adsr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage (17 stages).
// Depends on adsr_pkg. Quotient must fit 17 bits; sideband travels alongside.
module adsr_div import adsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [LEN_W-1:0]  den,
	input  side_t             side_in,
	output logic              out_valid,
	output logic [GAIN_W-1:0] quot,
	output side_t             side_out
);

	logic [NUM_W-1:0]  rem_s  [DIV_STAGES];
	logic [LEN_W-1:0]  den_s  [DIV_STAGES];
	logic [GAIN_W-1:0] quot_s [DIV_STAGES];
	side_t             side_s [DIV_STAGES];
	logic              vld_s  [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		localparam int K = DIV_STAGES - 1 - i;
		logic [NUM_W-1:0]  rem_in;
		logic [LEN_W-1:0]  den_in;
		logic [GAIN_W-1:0] quot_in;
		side_t             side_in_i;
		logic              vld_in;
		logic [NUM_W-1:0]  trial;
		logic              ge;

		if (i == 0) begin : g_first
			assign rem_in    = num;
			assign den_in    = den;
			assign quot_in   = '0;
			assign side_in_i = side_in;
			assign vld_in    = in_valid;
		end else begin : g_next
			assign rem_in    = rem_s[i-1];
			assign den_in    = den_s[i-1];
			assign quot_in   = quot_s[i-1];
			assign side_in_i = side_s[i-1];
			assign vld_in    = vld_s[i-1];
		end

		assign trial = {{(NUM_W-LEN_W){1'b0}}, den_in} << K;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? rem_in - trial : rem_in;
				den_s[i]  <= den_in;
				quot_s[i] <= quot_in | ({{(GAIN_W-1){1'b0}}, ge} << K);
				side_s[i] <= side_in_i;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quot      = quot_s[DIV_STAGES-1];
	assign side_out  = side_s[DIV_STAGES-1];

endmodule

// ===== src/adsr_front.sv =====
// Phase decode and numerator build for the held level (stages s1..s4).
// Depends on adsr_pkg; feeds the first adsr_div.
module adsr_front import adsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  cfg_t             cfg,
	input  logic             in_valid,
	input  logic [CNT_W-1:0] elapsed_count,
	input  logic             is_released,
	input  logic [CNT_W-1:0] release_point,
	output logic             out_valid,
	output logic [NUM_W-1:0] num,
	output logic [LEN_W-1:0] den,
	output side_t            side
);

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [CNT_W-1:0] u_s1, dt_s1;
	logic             rel_s1, rel_s2, rel_s3;
	logic             att_s2, dec_s2, att_s3, dec_s3;
	logic [LEN_W-1:0] u_s2, e_s2, u_s3;
	logic             relz_s2, relz_s3;
	logic [LEN_W-1:0] remt_s2, remt_s3;
	logic [NUM_W-1:0] prod_s3;
	logic [NUM_W-1:0] num_s4;
	logic [LEN_W-1:0] den_s4;
	side_t            side_s4;

	logic [CNT_W:0]   ad_sum;
	logic [GAIN_W-1:0] gap;

	assign ad_sum = {{(CNT_W-LEN_W+1){1'b0}}, cfg.attack_length}
		+ {{(CNT_W-LEN_W+1){1'b0}}, cfg.decay_length};
	assign gap = GAIN_W'(FULL_SCALE) - cfg.sustain_gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: pick the time that sets the held level, clamp time since release
			u_s1   <= is_released ? release_point : elapsed_count;
			dt_s1  <= (release_point > elapsed_count) ? '0 : elapsed_count - release_point;
			rel_s1 <= is_released;
			// s2: phase decode
			att_s2  <= u_s1 < {{(CNT_W-LEN_W){1'b0}}, cfg.attack_length};
			dec_s2  <= {1'b0, u_s1} < ad_sum;
			u_s2    <= u_s1[LEN_W-1:0];
			e_s2    <= u_s1[LEN_W-1:0] - cfg.attack_length;
			rel_s2  <= rel_s1;
			relz_s2 <= dt_s1 >= {{(CNT_W-LEN_W){1'b0}}, cfg.release_length};
			remt_s2 <= cfg.release_length - dt_s1[LEN_W-1:0];
			// s3: decay slope product
			prod_s3 <= NUM_W'(e_s2) * NUM_W'(gap);
			att_s3  <= att_s2;
			dec_s3  <= dec_s2;
			u_s3    <= u_s2;
			rel_s3  <= rel_s2;
			relz_s3 <= relz_s2;
			remt_s3 <= remt_s2;
			// s4: numerator and divisor
			num_s4 <= att_s3 ? {1'b0, u_s3, 16'h0000}
				: {1'b0, cfg.decay_length, 16'h0000} - prod_s3;
			den_s4 <= att_s3 ? cfg.attack_length : cfg.decay_length;
			side_s4.bypass     <= !att_s3 && !dec_s3;
			side_s4.bypass_val <= cfg.sustain_gain;
			side_s4.rel        <= rel_s3;
			side_s4.rel_zero   <= relz_s3;
			side_s4.rem_time   <= remt_s3;
		end
	end

	assign out_valid = vld_s4;
	assign num       = num_s4;
	assign den       = den_s4;
	assign side      = side_s4;

endmodule

// ===== src/adsr_rel.sv =====
// Release scaling: turns the held level into the release numerator (stage r1).
// Depends on adsr_pkg; sits between the two adsr_div instances.
module adsr_rel import adsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [GAIN_W-1:0] quot,
	input  side_t             side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  num,
	output side_t             side_out
);

	logic              vld_s1;
	logic [NUM_W-1:0]  num_s1;
	side_t             side_s1;
	logic [GAIN_W-1:0] level;

	assign level = side_in.bypass ? side_in.bypass_val : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= NUM_W'(level) * NUM_W'(side_in.rem_time);
			side_s1.bypass     <= !side_in.rel || side_in.rel_zero;
			side_s1.bypass_val <= side_in.rel ? '0 : level;
			side_s1.rel        <= side_in.rel;
			side_s1.rel_zero   <= side_in.rel_zero;
			side_s1.rem_time   <= side_in.rem_time;
		end
	end

	assign out_valid = vld_s1;
	assign num       = num_s1;
	assign side_out  = side_s1;

endmodule

// ===== src/adsr_envelope_factor_top.sv =====
// Channel  | beat fields (low bit up)                        | width
// s_axis   | tdata: elapsed_count[31:0], release_point[63:32]; tuser: is_released | 64+1
// m_axis   | tdata: gain[16:0], zero pad to 24               | 24
// cfg      | cfg_index: register 0..3, cfg_data: value        | 2+24
// One beat accepted per cycle while the output is not stalled; the pipeline is 4 decode stages,
// two 17-stage dividers, one release multiply stage and an output register.
// Reset clears valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Depends on adsr_pkg, adsr_front, adsr_div, adsr_rel.
module adsr_envelope_factor_top import adsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // elapsed_count[31:0], release_point[63:32]
	input  logic        s_tuser,   // is_released
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // gain[16:0], zeros above
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t              cfg_q;
	logic              en;
	logic              f_valid, d1_valid, r_valid, d2_valid;
	logic [NUM_W-1:0]  f_num, r_num;
	logic [LEN_W-1:0]  f_den;
	side_t             f_side, d1_side, r_side, d2_side;
	logic [GAIN_W-1:0] d1_quot, d2_quot;
	logic              out_valid_q;
	logic [GAIN_W-1:0] gain_q;
	logic [GAIN_W-1:0] sus_val;

	assign cfg_ready = 1'b1;
	assign sus_val   = (cfg_data[GAIN_W-1:0] > GAIN_W'(FULL_SCALE))
		? GAIN_W'(FULL_SCALE) : cfg_data[GAIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_length  <= '0;
			cfg_q.decay_length   <= '0;
			cfg_q.sustain_gain   <= GAIN_W'(FULL_SCALE);
			cfg_q.release_length <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ATTACK:  cfg_q.attack_length  <= cfg_data;
				REG_DECAY:   cfg_q.decay_length   <= cfg_data;
				REG_SUSTAIN: cfg_q.sustain_gain   <= sus_val;
				REG_RELEASE: cfg_q.release_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance everything unless a finished beat is blocked
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	adsr_front u_front (
		.clk, .arst_n, .en, .cfg(cfg_q),
		.in_valid(s_tvalid),
		.elapsed_count(s_tdata[31:0]),
		.is_released(s_tuser),
		.release_point(s_tdata[63:32]),
		.out_valid(f_valid), .num(f_num), .den(f_den), .side(f_side)
	);

	adsr_div u_div_held (
		.clk, .arst_n, .en,
		.in_valid(f_valid), .num(f_num), .den(f_den), .side_in(f_side),
		.out_valid(d1_valid), .quot(d1_quot), .side_out(d1_side)
	);

	adsr_rel u_rel (
		.clk, .arst_n, .en,
		.in_valid(d1_valid), .quot(d1_quot), .side_in(d1_side),
		.out_valid(r_valid), .num(r_num), .side_out(r_side)
	);

	adsr_div u_div_rel (
		.clk, .arst_n, .en,
		.in_valid(r_valid), .num(r_num), .den(cfg_q.release_length), .side_in(r_side),
		.out_valid(d2_valid), .quot(d2_quot), .side_out(d2_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gain_q <= d2_side.bypass ? d2_side.bypass_val : d2_quot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24-GAIN_W){1'b0}}, gain_q};

endmodule

// ===== test/adsr_envelope_factor_top_tb.sv =====
// Self-checking bench for the ADSR envelope gain pipeline: random and directed
// beats against an in-bench gain predictor. Depends on adsr_pkg and the top.
module adsr_envelope_factor_top_tb;
	import adsr_pkg::*;

	typedef struct packed {
		logic [31:0] elapsed;
		logic        released;
		logic [31:0] rel_point;
	} note_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	adsr_envelope_factor_top dut (.*);

	logic [23:0] atk_len, dec_len, rel_len;
	logic [16:0] sus_lvl;

	note_beat_t  pending_notes[$];
	logic [16:0] expected_gains[$];
	int          fail_count;
	int          gains_seen;
	bit          src_idle_on;
	bit          sink_idle_on;
	bit          sink_hold;
	int          hold_cycles;
	logic        s_tready_q;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic logic [16:0] held_level(logic [31:0] t);
		logic [63:0] a, d, s, tt, e;
		a  = atk_len;
		d  = dec_len;
		s  = sus_lvl;
		tt = t;
		if (tt < a)
			return 17'((tt * FULL_SCALE) / a);
		if (tt < a + d) begin
			e = tt - a;
			return 17'((64'(FULL_SCALE) * d - e * (64'(FULL_SCALE) - s)) / d);
		end
		return 17'(s);
	endfunction

	function automatic logic [16:0] envelope_gain(note_beat_t b);
		logic [63:0] r, dt, g;
		if (b.released) begin
			r  = rel_len;
			dt = (b.rel_point > b.elapsed) ? 64'd0 : 64'(b.elapsed - b.rel_point);
			if (dt >= r)
				g = 0;
			else
				g = (64'(held_level(b.rel_point)) * (r - dt)) / r;
		end else begin
			g = held_level(b.elapsed);
		end
		if (g > FULL_SCALE)
			g = FULL_SCALE;
		return 17'(g);
	endfunction

	// driver: a beat leaves the queue when it is accepted
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready_q)
				void'(pending_notes.pop_front());
			if (pending_notes.size() > 0 && !(src_idle_on && $urandom_range(99) < 36)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {pending_notes[0].rel_point, pending_notes[0].elapsed};
				s_tuser  <= pending_notes[0].released;
			end else if (!(s_tvalid && !s_tready_q)) begin
				s_tvalid <= 1'b0;
			end
			if (sink_hold)
				m_tready <= 1'b0;
			else
				m_tready <= !(sink_idle_on && $urandom_range(99) < 36);
		end
	end

	// accept flag sampled at the rising edge, used by the driver at the next fall
	always @(posedge clk) begin
		s_tready_q <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			expected_gains.insert(expected_gains.size(),
				envelope_gain({s_tdata[31:0], s_tuser, s_tdata[63:32]}));
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			gains_seen++;
			if (expected_gains.size() == 0) begin
				$error("gain beat with nothing expected: %0d", m_tdata[16:0]);
				fail_count++;
			end else begin
				if (m_tdata[16:0] !== expected_gains[0]) begin
					$error("gain: expected %0d actual %0d", expected_gains[0], m_tdata[16:0]);
					fail_count++;
				end
				if (m_tdata[23:17] !== 7'd0) begin
					$error("tdata pad: expected 0 actual %0h", m_tdata[23:17]);
					fail_count++;
				end
				void'(expected_gains.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (sink_hold)
			hold_cycles++;
		else
			hold_cycles = 0;
	end

	task automatic drain();
		while (pending_notes.size() > 0 || s_tvalid || expected_gains.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic queue_note(note_beat_t b);
		pending_notes.insert(pending_notes.size(), b);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ATTACK:  atk_len = val;
			REG_DECAY:   dec_len = val;
			REG_SUSTAIN: sus_lvl = (val[16:0] > FULL_SCALE) ? 17'(FULL_SCALE) : val[16:0];
			REG_RELEASE: rel_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] pick_len();
		case ($urandom_range(5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(1, 4));
			3: return 24'($urandom_range(1, 300));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic note_beat_t rand_note();
		note_beat_t b;
		logic [31:0] span;
		span = 32'(atk_len) + 32'(dec_len) + 32'(rel_len) + 32'd8;
		b.released = 1'($urandom_range(1));
		if ($urandom_range(9) < 7) begin
			b.rel_point = $urandom_range(0, span);
			b.elapsed   = b.rel_point + $urandom_range(0, 32'(rel_len) + 4);
			if (!b.released)
				b.elapsed = $urandom_range(0, span);
		end else begin
			b.elapsed   = $urandom;
			b.rel_point = $urandom;
		end
		return b;
	endfunction

	task automatic push_phase(int n);
		repeat (n) queue_note(rand_note());
	endtask

	initial begin
		fail_count   = 0;
		gains_seen   = 0;
		arst_n       = 0;
		s_tvalid     = 0;
		s_tdata      = '0;
		s_tuser      = 0;
		m_tready     = 0;
		cfg_valid    = 0;
		cfg_index    = REG_ATTACK;
		cfg_data     = '0;
		src_idle_on  = 0;
		sink_idle_on = 0;
		sink_hold    = 0;
		atk_len      = 0;
		dec_len      = 0;
		sus_lvl      = 17'(FULL_SCALE);
		rel_len      = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset defaults: zero attack/decay skip, zero release gives zero
		queue_note('{32'd0, 1'b0, 32'd0});
		queue_note('{32'hFFFFFFFF, 1'b1, 32'd0});
		drain();

		write_reg(REG_ATTACK, 24'd100);
		write_reg(REG_DECAY, 24'd50);
		write_reg(REG_SUSTAIN, 24'd20000);
		write_reg(REG_RELEASE, 24'd200);
		queue_note('{32'd0, 1'b0, 32'd0});
		queue_note('{32'd50, 1'b0, 32'd0});
		queue_note('{32'd100, 1'b0, 32'd0});
		queue_note('{32'd125, 1'b0, 32'd0});
		queue_note('{32'd150, 1'b0, 32'd0});
		queue_note('{32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF});
		queue_note('{32'd120, 1'b1, 32'd120});
		queue_note('{32'd10, 1'b1, 32'd130});    // release point in future
		queue_note('{32'd299, 1'b1, 32'd100});
		queue_note('{32'd300, 1'b1, 32'd100});   // release just over
		queue_note('{32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF});
		queue_note('{32'h80000000, 1'b1, 32'h7FFFFFFF});
		drain();

		write_reg(REG_SUSTAIN, 24'h1FFFF);  // saturates to full scale
		write_reg(REG_ATTACK, 24'hFFFFFF);
		write_reg(REG_DECAY, 24'hFFFFFF);
		write_reg(REG_RELEASE, 24'hFFFFFF);
		queue_note('{32'h00FFFFFE, 1'b0, 32'd0});
		queue_note('{32'h01FFFFFD, 1'b0, 32'd0});
		queue_note('{32'h02000000, 1'b1, 32'h00FFFFFF});
		queue_note('{32'h55555555, 1'b1, 32'hAAAAAAAA});
		queue_note('{32'hAAAAAAAA, 1'b0, 32'h55555555});
		drain();
		write_reg(REG_SUSTAIN, 24'd0);

		// long receiver hold-off to back the pipeline up into the input
		src_idle_on = 1;
		sink_idle_on = 1;
		sink_hold = 1;
		push_phase(100);
		wait (hold_cycles >= 300);
		sink_hold = 0;
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_ATTACK, pick_len());
			write_reg(REG_DECAY, pick_len());
			write_reg(REG_SUSTAIN, ($urandom_range(3) == 0) ? 24'($urandom_range(0, 1) * FULL_SCALE)
				: 24'($urandom_range(0, 17'h1FFFF)));
			write_reg(REG_RELEASE, pick_len());
			src_idle_on  = (ph != 2);
			sink_idle_on = (ph != 2);
			push_phase(100);
			drain();
		end

		$display("covered %0d gain beats over 11 register settings, with stalls and a hold-off",
			gains_seen);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule
